[rtl/sptc_pkg.sv]
// Shared constants, types and helpers for the scalar-to-palette colour map.
package sptc_pkg;

	localparam int PALETTE_DEPTH_DEF = 1024;
	localparam int ARGB_W            = 32;
	localparam int DIV_STAGES        = 32;

	localparam logic [31:0] BLACK_ARGB      = 32'hFF00_0000;
	localparam logic [31:0] RANGE_LOWER_RST = 32'd0;
	localparam logic [31:0] INDEX_SCALE_RST = 32'd65536;
	localparam logic [10:0] LEVEL_COUNT_RST = 11'd350;
	localparam logic        PERIODIC_RST    = 1'b0;

	localparam int          CFG_IDX_W       = 2;
	localparam logic [1:0]  CFG_RANGE_LOWER = 2'd0;
	localparam logic [1:0]  CFG_INDEX_SCALE = 2'd1;
	localparam logic [1:0]  CFG_LEVEL_COUNT = 2'd2;
	localparam logic [1:0]  CFG_PERIODIC    = 2'd3;

	localparam logic OP_MAP   = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// per-request fields that ride along the index pipeline
	typedef struct packed {
		logic        op;
		logic        wr_ok;
		logic [9:0]  entry_index;
		logic [31:0] entry_color;
		logic [7:0]  alpha;
		logic        last;
	} sptc_side_t;

	// floor(x / 255), exact for x up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = 17'(x) + 17'(x[15:8]) + 17'd1;
		return s[15:8];
	endfunction

endpackage

[rtl/sptc_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module sptc_ram import sptc_pkg::*; #(
	parameter int WIDTH = ARGB_W,
	parameter int DEPTH = PALETTE_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/sptc_index.sv]
// Palette index pipeline: offset, Q16.16 scale, saturation, clamp and modulo.
module sptc_index import sptc_pkg::*; #(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
	localparam int AW = $clog2(PALETTE_DEPTH),
	localparam int LW = $clog2(PALETTE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               take,
	input  logic               op,
	input  logic signed [31:0] sample_value,
	input  logic [7:0]         pixel_alpha,
	input  logic               last_pixel,
	input  logic [9:0]         entry_index,
	input  logic [31:0]        entry_color,
	input  logic [31:0]        range_lower,
	input  logic [31:0]        index_scale,
	input  logic [LW-1:0]      lc_eff,
	input  logic               periodic,
	output logic               req_valid,
	output sptc_side_t         req_side,
	output logic [AW-1:0]      req_addr
);

	localparam int LAST = DIV_STAGES - 1;

	// stage 1: offset from lower bound, as sign and magnitude
	logic [32:0] diff;
	logic [32:0] mag;
	sptc_side_t  side_in;

	logic        valid_s1;
	sptc_side_t  side_s1;
	logic        neg_s1;
	logic [32:0] mag_s1;

	// stage 2: integer part of the product
	logic [63:0] prod;
	logic [31:0] ip;

	logic        valid_s2;
	sptc_side_t  side_s2;
	logic        neg_s2;
	logic [31:0] ip_s2;

	// stage 3: saturated magnitude and clamped index
	logic [31:0]   msat;
	logic [AW-1:0] clamp;

	logic          valid_s3;
	sptc_side_t    side_s3;
	logic          neg_s3;
	logic [31:0]   mag_s3;
	logic [AW-1:0] clamp_s3;

	// remainder stages, one quotient bit each; element k is stage 4+k
	logic          div_valid_s4 [DIV_STAGES];
	sptc_side_t    div_side_s4  [DIV_STAGES];
	logic          div_neg_s4   [DIV_STAGES];
	logic [AW-1:0] div_clamp_s4 [DIV_STAGES];
	logic [LW-1:0] div_rem_s4   [DIV_STAGES];
	logic [31:0]   div_mag_s4   [DIV_STAGES];

	logic          src_valid [DIV_STAGES];
	sptc_side_t    src_side  [DIV_STAGES];
	logic          src_neg   [DIV_STAGES];
	logic [AW-1:0] src_clamp [DIV_STAGES];
	logic [LW-1:0] src_rem   [DIV_STAGES];
	logic [31:0]   src_mag   [DIV_STAGES];
	logic [LW:0]   trial     [DIV_STAGES];
	logic [LW-1:0] rem_nx    [DIV_STAGES];

	logic [LW-1:0] rem_end;
	logic [LW-1:0] wrapped;

	assign diff = {sample_value[31], sample_value} - {range_lower[31], range_lower};
	assign mag  = diff[32] ? (33'd0 - diff) : diff;

	always_comb begin
		side_in.op          = op;
		side_in.wr_ok       = 32'(entry_index) < 32'(PALETTE_DEPTH);
		side_in.entry_index = entry_index;
		side_in.entry_color = entry_color;
		side_in.alpha       = pixel_alpha;
		side_in.last        = last_pixel;
	end

	// magnitude of 2^32 only arises with a zero low word
	assign prod = 64'(mag_s1[31:0]) * 64'(index_scale);
	assign ip   = mag_s1[32] ? index_scale : prod[63:32];

	assign msat  = ip_s2[31] ? {neg_s2, {31{~neg_s2}}} : ip_s2;
	assign clamp = neg_s2 ? '0 :
		((msat >= 32'(lc_eff)) ? AW'(lc_eff - LW'(1)) : AW'(msat));

	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				src_valid[k] = valid_s3;
				src_side[k]  = side_s3;
				src_neg[k]   = neg_s3;
				src_clamp[k] = clamp_s3;
				src_rem[k]   = '0;
				src_mag[k]   = mag_s3;
			end else begin
				src_valid[k] = div_valid_s4[k-1];
				src_side[k]  = div_side_s4[k-1];
				src_neg[k]   = div_neg_s4[k-1];
				src_clamp[k] = div_clamp_s4[k-1];
				src_rem[k]   = div_rem_s4[k-1];
				src_mag[k]   = div_mag_s4[k-1];
			end
			trial[k]  = {src_rem[k], src_mag[k][31]};
			rem_nx[k] = (trial[k] >= {1'b0, lc_eff}) ?
				LW'(trial[k] - {1'b0, lc_eff}) : LW'(trial[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			for (int k = 0; k < DIV_STAGES; k++) begin
				div_valid_s4[k] <= 1'b0;
			end
		end else if (adv) begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			for (int k = 0; k < DIV_STAGES; k++) begin
				div_valid_s4[k] <= src_valid[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1  <= side_in;
			neg_s1   <= diff[32];
			mag_s1   <= mag;
			side_s2  <= side_s1;
			neg_s2   <= neg_s1;
			ip_s2    <= ip;
			side_s3  <= side_s2;
			neg_s3   <= neg_s2;
			mag_s3   <= msat;
			clamp_s3 <= clamp;
			for (int k = 0; k < DIV_STAGES; k++) begin
				div_side_s4[k]  <= src_side[k];
				div_neg_s4[k]   <= src_neg[k];
				div_clamp_s4[k] <= src_clamp[k];
				div_rem_s4[k]   <= rem_nx[k];
				div_mag_s4[k]   <= {src_mag[k][30:0], 1'b0};
			end
		end
	end

	// negative index: a nonzero remainder folds back from the top
	assign rem_end  = div_rem_s4[LAST];
	assign wrapped  = (div_neg_s4[LAST] && (rem_end != '0)) ? (lc_eff - rem_end) : rem_end;

	assign req_valid = div_valid_s4[LAST];
	assign req_side  = div_side_s4[LAST];
	assign req_addr  = periodic ? AW'(wrapped) : div_clamp_s4[LAST];

endmodule

[rtl/sptc_shade.sv]
// Per-pixel alpha scaling of the palette word, floor(c * alpha / 255) per byte.
module sptc_shade import sptc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              rd_valid,
	input  logic [ARGB_W-1:0] rdata,
	input  logic [7:0]        alpha,
	input  logic              last,
	output logic              tail_valid,
	output logic [ARGB_W-1:0] tail_color,
	output logic              tail_last
);

	logic [15:0] prod_nx [4];
	logic [15:0] prod_s1 [4];
	logic        valid_s1;
	logic        last_s1;

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			prod_nx[b] = 16'(rdata[8*b +: 8]) * 16'(alpha);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= rd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= last;
			for (int b = 0; b < 4; b++) begin
				prod_s1[b] <= prod_nx[b];
			end
		end
	end

	// opaque alpha gives c * 255 / 255 = c, so no bypass is needed
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			tail_color[8*b +: 8] = div255(prod_s1[b]);
		end
	end

	assign tail_valid = valid_s1;
	assign tail_last  = last_s1;

endmodule

[rtl/scalar_to_palette_color_map.sv]
// Pipeline: a map request passes 35 index stages, one palette read, one alpha stage
// and the output register to pixel_color; palette writes take effect in request order.
// Throughput: one request per cycle, by the one-bit-per-stage remainder pipeline; a skid
// slot takes one result on an output stall, and all stages hold while it is occupied.
// Reset: configuration returns to its defaults and the palette is swept to opaque
// black, one entry per cycle over all PALETTE_DEPTH entries, with in_ready held low.
module scalar_to_palette_color_map import sptc_pkg::*; #(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic signed [31:0]   sample_value,
	input  logic [7:0]           pixel_alpha,
	input  logic                 last_pixel,
	input  logic [9:0]           entry_index,
	input  logic [31:0]          entry_color,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          pixel_color,
	output logic                 line_end,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int LW = $clog2(PALETTE_DEPTH + 1);

	logic        [31:0] range_lower_q;
	logic        [31:0] index_scale_q;
	logic        [10:0] level_count_q;
	logic               periodic_q;
	logic      [LW-1:0] lc_eff;

	logic               clearing_q;
	logic      [AW-1:0] clr_addr_q;

	logic               adv;
	logic               take;

	logic               req_valid;
	sptc_side_t         req_side;
	logic      [AW-1:0] req_addr;

	logic               ram_we;
	logic      [AW-1:0] ram_waddr;
	logic  [ARGB_W-1:0] ram_wdata;
	logic               ram_re;
	logic  [ARGB_W-1:0] ram_rdata;

	logic               rd_valid_s1;
	logic         [7:0] rd_alpha_s1;
	logic               rd_last_s1;

	logic               tail_valid;
	logic  [ARGB_W-1:0] tail_color;
	logic               tail_last;

	logic               out_valid_q;
	logic  [ARGB_W-1:0] out_color_q;
	logic               out_last_q;
	logic               skid_valid_q;
	logic  [ARGB_W-1:0] skid_color_q;
	logic               skid_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_lower_q <= RANGE_LOWER_RST;
			index_scale_q <= INDEX_SCALE_RST;
			level_count_q <= LEVEL_COUNT_RST;
			periodic_q    <= PERIODIC_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RANGE_LOWER: range_lower_q <= cfg_data;
				CFG_INDEX_SCALE: index_scale_q <= cfg_data;
				CFG_LEVEL_COUNT: level_count_q <= cfg_data[10:0];
				CFG_PERIODIC:    periodic_q    <= cfg_data[0];
			endcase
		end
	end

	always_comb begin
		if (32'(level_count_q) < 32'd2) begin
			lc_eff = LW'(2);
		end else if (32'(level_count_q) > 32'(PALETTE_DEPTH)) begin
			lc_eff = LW'(PALETTE_DEPTH);
		end else begin
			lc_eff = LW'(level_count_q);
		end
	end

	// palette clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(PALETTE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// whole pipeline moves unless the skid slot is occupied
	assign adv      = !skid_valid_q;
	assign in_ready = adv && !clearing_q;
	assign take     = in_valid && in_ready;

	sptc_index #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_index (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.take         (take),
		.op           (op),
		.sample_value (sample_value),
		.pixel_alpha  (pixel_alpha),
		.last_pixel   (last_pixel),
		.entry_index  (entry_index),
		.entry_color  (entry_color),
		.range_lower  (range_lower_q),
		.index_scale  (index_scale_q),
		.lc_eff       (lc_eff),
		.periodic     (periodic_q),
		.req_valid    (req_valid),
		.req_side     (req_side),
		.req_addr     (req_addr)
	);

	// at most one palette access per request: write for an in-range load, read for a map
	assign ram_we    = clearing_q ||
		(adv && req_valid && (req_side.op == OP_WRITE) && req_side.wr_ok);
	assign ram_waddr = clearing_q ? clr_addr_q : AW'(req_side.entry_index);
	assign ram_wdata = clearing_q ? BLACK_ARGB : req_side.entry_color;
	assign ram_re    = adv && req_valid && (req_side.op == OP_MAP);

	sptc_ram #(
		.WIDTH (ARGB_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (req_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else if (adv) begin
			rd_valid_s1 <= req_valid && (req_side.op == OP_MAP);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_alpha_s1 <= req_side.alpha;
			rd_last_s1  <= req_side.last;
		end
	end

	sptc_shade u_shade (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.rd_valid   (rd_valid_s1),
		.rdata      (ram_rdata),
		.alpha      (rd_alpha_s1),
		.last       (rd_last_s1),
		.tail_valid (tail_valid),
		.tail_color (tail_color),
		.tail_last  (tail_last)
	);

	// output register with one skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= tail_valid;
			end
		end else if (tail_valid && adv) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_color_q <= skid_color_q;
				out_last_q  <= skid_last_q;
			end else begin
				out_color_q <= tail_color;
				out_last_q  <= tail_last;
			end
		end else if (tail_valid && adv) begin
			skid_color_q <= tail_color;
			skid_last_q  <= tail_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_color = out_color_q;
	assign line_end    = out_last_q;

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot holds a request while the output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid slot filled without an output stall");

	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !ram_re && !take)
		else $error("palette read or request taken during clearing sweep");
`endif

endmodule

[verif/scalar_to_palette_color_map_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the scalar-to-palette colour map with predictor and scoreboard.
module scalar_to_palette_color_map_test import sptc_pkg::*;;

	localparam int PALETTE_DEPTH = PALETTE_DEPTH_DEF;
	localparam int PIPE_DRAIN    = 48;
	localparam int CYCLE_LIMIT   = 300000;

	typedef struct {
		logic               op;
		logic signed [31:0] sample;
		logic [7:0]         alpha;
		logic               last;
		logic [9:0]         slot;
		logic [31:0]        argb;
	} pixel_req_t;

	typedef struct {
		logic [31:0] pixel_color;
		logic        line_end;
	} pixel_due_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic                 op           = OP_MAP;
	logic signed [31:0]   sample_value = '0;
	logic [7:0]           pixel_alpha  = 8'd255;
	logic                 last_pixel   = 1'b0;
	logic [9:0]           entry_index  = '0;
	logic [31:0]          entry_color  = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [31:0]          pixel_color;
	logic                 line_end;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_RANGE_LOWER;
	logic [31:0]          cfg_data     = '0;

	// predictor copy of the block's settings and palette
	logic signed [31:0] set_lower;
	logic [31:0]        set_scale;
	logic [10:0]        set_levels;
	logic               set_wrap;
	logic [31:0]        palette_copy [PALETTE_DEPTH];

	pixel_req_t pending_reqs [$];
	pixel_due_t awaited_pixels [$];
	pixel_req_t staged;
	pixel_due_t head_due;
	bit         holding    = 1'b0;
	bit         burst_mode = 1'b0;
	int         idle_left  = 0;
	int         stall_left = 0;
	int         mismatches = 0;
	int         cycle_count = 0;

	scalar_to_palette_color_map i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int draw_idle();
		if (burst_mode)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	function automatic longint live_levels();
		longint levels;
		levels = longint'(set_levels);
		if (levels < 2)
			levels = 2;
		if (levels > PALETTE_DEPTH)
			levels = PALETTE_DEPTH;
		return levels;
	endfunction

	// integer part of (sample - lower) * scale, saturated, then wrapped or clamped
	function automatic longint palette_slot(input logic signed [31:0] sample);
		longint      levels;
		longint      diff;
		longint      slot;
		logic [63:0] mag;
		logic [63:0] whole;
		levels = live_levels();
		diff   = longint'(sample) - longint'(set_lower);
		mag    = (diff < 0) ? 64'(-diff) : 64'(diff);
		whole  = (mag * {32'b0, set_scale}) >> 32;
		if (diff >= 0) begin
			if (whole > 64'h7FFF_FFFF)
				whole = 64'h7FFF_FFFF;
			slot = longint'(whole);
		end else begin
			if (whole > 64'h8000_0000)
				whole = 64'h8000_0000;
			slot = -longint'(whole);
		end
		if (set_wrap) begin
			slot = slot % levels;
			if (slot < 0)
				slot += levels;
		end else if (slot < 0) begin
			slot = 0;
		end else if (slot >= levels) begin
			slot = levels - 1;
		end
		return slot;
	endfunction

	function automatic logic [31:0] fade_argb(input logic [31:0] argb, input logic [7:0] alpha);
		logic [31:0] faded;
		faded = argb;
		if (alpha != 8'd255)
			for (int b = 0; b < 4; b++)
				faded[8*b +: 8] = 8'((int'(argb[8*b +: 8]) * int'(alpha)) / 255);
		return faded;
	endfunction

	function automatic void absorb_request();
		pixel_due_t due;
		if (op == OP_WRITE) begin
			palette_copy[entry_index] = entry_color;
		end else begin
			due.pixel_color = fade_argb(palette_copy[palette_slot(sample_value)], pixel_alpha);
			due.line_end    = last_pixel;
			awaited_pixels.push_back(due);
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				absorb_request();
				holding = 1'b0;
			end
			if (!in_valid || in_ready) begin
				if (idle_left > 0) begin
					idle_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					staged = pending_reqs.pop_front();
					holding = 1'b1;
					op           <= staged.op;
					sample_value <= staged.sample;
					pixel_alpha  <= staged.alpha;
					last_pixel   <= staged.last;
					entry_index  <= staged.slot;
					entry_color  <= staged.argb;
					in_valid     <= 1'b1;
					idle_left = draw_idle();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and scoreboard
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_pixels.size() == 0) begin
					$error("pixel_color: expected nothing, got %h", pixel_color);
					mismatches++;
				end else begin
					head_due = awaited_pixels.pop_front();
					if (pixel_color !== head_due.pixel_color) begin
						$error("pixel_color: expected %h, got %h",
							head_due.pixel_color, pixel_color);
						mismatches++;
					end
					if (line_end !== head_due.line_end) begin
						$error("line_end: expected %b, got %b", head_due.line_end, line_end);
						mismatches++;
					end
				end
				stall_left = draw_idle();
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_map(input logic [31:0] sample, input logic [7:0] alpha, input logic last);
		pixel_req_t r;
		r.op     = OP_MAP;
		r.sample = sample;
		r.alpha  = alpha;
		r.last   = last;
		r.slot   = 10'($urandom);
		r.argb   = $urandom;
		pending_reqs.push_back(r);
	endtask

	task automatic push_write(input logic [9:0] slot, input logic [31:0] argb);
		pixel_req_t r;
		r.op     = OP_WRITE;
		r.sample = $urandom;
		r.alpha  = 8'($urandom);
		r.last   = 1'($urandom);
		r.slot   = slot;
		r.argb   = argb;
		pending_reqs.push_back(r);
	endtask

	// also lets in-flight palette writes land before any setting changes
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || holding || awaited_pixels.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic load_settings(input logic [31:0] lower, input logic [31:0] scale,
			input logic [10:0] levels, input logic wrap);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_RANGE_LOWER;
		cfg_data  <= lower;
		@(posedge clk);
		cfg_index <= CFG_INDEX_SCALE;
		cfg_data  <= scale;
		@(posedge clk);
		cfg_index <= CFG_LEVEL_COUNT;
		cfg_data  <= {21'b0, levels};
		@(posedge clk);
		cfg_index <= CFG_PERIODIC;
		cfg_data  <= {31'b0, wrap};
		@(posedge clk);
		cfg_we <= 1'b0;
		set_lower  = lower;
		set_scale  = scale;
		set_levels = levels;
		set_wrap   = wrap;
	endtask

	// mostly samples aimed just around the level range, the rest anywhere
	task automatic queue_random(input int count);
		longint levels;
		longint k;
		longint diff;
		logic [31:0] sample;
		levels = live_levels();
		for (int n = 0; n < count; n++) begin
			if (set_scale == 0 || $urandom_range(0, 9) < 3) begin
				sample = $urandom;
			end else begin
				k = longint'($urandom_range(0, int'(4 * levels))) - levels;
				diff = ((k <<< 32) + longint'($urandom)) / longint'({32'b0, set_scale});
				sample = 32'(longint'(set_lower) + diff);
			end
			if ($urandom_range(0, 3) == 0)
				push_write(($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, int'(levels) - 1))
					: 10'($urandom), $urandom);
			else
				push_map(sample, ($urandom_range(0, 2) == 0) ? 8'd255 : 8'($urandom),
					1'($urandom));
		end
	endtask

	task automatic random_phase(input logic [31:0] lower, input logic [31:0] scale,
			input logic [10:0] levels, input logic wrap);
		load_settings(lower, scale, levels, wrap);
		burst_mode = ($urandom_range(0, 3) == 0);
		queue_random(70);
		wait_idle();
	endtask

	initial begin
		for (int i = 0; i < PALETTE_DEPTH; i++)
			palette_copy[i] = BLACK_ARGB;
		set_lower  = RANGE_LOWER_RST;
		set_scale  = INDEX_SCALE_RST;
		set_levels = LEVEL_COUNT_RST;
		set_wrap   = PERIODIC_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// settings straight out of reset, untouched palette at index 3
		push_map(32'h0003_0000, 8'd255, 1'b0);
		push_write(10'd0, 32'hFFFF_FFFF);
		push_write(10'd1, 32'h80FF_7F01);
		push_write(10'd2, 32'h0000_0000);
		push_write(10'd349, 32'h1234_5678);
		push_write(10'd1023, 32'hA5A5_A5A5);
		push_map(32'h0000_0000, 8'd255, 1'b1);
		push_map(32'h0000_0000, 8'd0, 1'b0);
		push_map(32'h0000_FFFF, 8'd254, 1'b0);
		push_map(32'h0001_0000, 8'd128, 1'b1);
		push_map(32'h015D_0000, 8'd255, 1'b0);
		push_map(32'h015E_0000, 8'd255, 1'b0);
		push_map(32'h7FFF_FFFF, 8'd255, 1'b0);
		push_map(32'h8000_0000, 8'd1, 1'b1);
		wait_idle();

		// widest range, largest scale, full palette, wrapping
		load_settings(32'h8000_0000, 32'hFFFF_FFFF, 11'd1024, 1'b1);
		push_map(32'h8000_0000, 8'd255, 1'b0);
		push_map(32'h7FFF_FFFF, 8'd200, 1'b1);
		push_map(32'h8000_0001, 8'd255, 1'b0);
		wait_idle();

		// zero scale with level count of zero: everything lands on entry 0
		load_settings(32'h7FFF_FFFF, 32'h0000_0000, 11'd0, 1'b0);
		push_map(32'h8000_0000, 8'd255, 1'b0);
		push_map(32'h1234_5678, 8'd77, 1'b1);
		wait_idle();

		// a level count of one acts as two levels and wraps a negative index onto the top entry
		load_settings(32'h0000_0000, 32'h0001_0000, 11'd1, 1'b1);
		push_map(32'hFFFF_0000, 8'd255, 1'b0);
		wait_idle();

		// level count past the palette depth
		load_settings(32'h0000_0000, 32'h0001_0000, 11'd2047, 1'b0);
		push_map(32'h03FF_0000, 8'd255, 1'b0);
		push_map(32'h07D0_0000, 8'd255, 1'b1);
		wait_idle();

		random_phase(RANGE_LOWER_RST, INDEX_SCALE_RST, LEVEL_COUNT_RST, PERIODIC_RST);
		random_phase(32'h8000_0000, 32'hFFFF_FFFF, 11'd1024, 1'b1);
		random_phase(32'h7FFF_FFFF, 32'h0000_0000, 11'd0, 1'b0);
		random_phase($urandom, $urandom, 11'd2047, 1'b1);
		random_phase($urandom, $urandom_range(32'h1000, 32'h10_0000),
			11'($urandom_range(2, 16)), 1'b1);
		random_phase($urandom, $urandom, 11'd2, 1'b0);
		random_phase($urandom, $urandom_range(32'h100, 32'h100_0000),
			11'($urandom_range(0, 2047)), 1'($urandom));
		random_phase($urandom, $urandom, 11'($urandom), 1'($urandom));

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[scalar_to_palette_color_map.f]
rtl/sptc_pkg.sv
rtl/sptc_ram.sv
rtl/sptc_index.sv
rtl/sptc_shade.sv
rtl/scalar_to_palette_color_map.sv
verif/scalar_to_palette_color_map_test.sv
